[design/rc5ir_pkg.sv]
// Shared types and constants for the RC5 infrared frame decoder.
// No dependencies; imported by every module of the decoder.
package rc5ir_pkg;

   localparam int DelayWidth    = 16;
   localparam int AddrWidth     = 5;
   localparam int CmdWidth      = 6;
   localparam int FrameBits     = 12;
   localparam int BitIdxWidth   = 4;
   localparam int LampCount     = 7;
   localparam int CsrIndexWidth = 2;

   // register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] CsrFirstDelay   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBitDelay     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrAddressMatch = 2'd2;

   localparam logic [DelayWidth-1:0] FirstDelayReset   = 16'd7;
   localparam logic [DelayWidth-1:0] BitDelayReset     = 16'd4;
   localparam logic [AddrWidth-1:0]  AddressMatchReset = 5'd0;

   localparam logic [BitIdxWidth-1:0] LastBitIndex = 4'(FrameBits - 1);
   localparam logic [CmdWidth-1:0]    CmdLampLo    = 6'd1;
   localparam logic [CmdWidth-1:0]    CmdLampHi    = 6'(LampCount);

   typedef struct packed {
      logic [DelayWidth-1:0] first_delay;
      logic [DelayWidth-1:0] bit_delay;
      logic [AddrWidth-1:0]  address_match;
   } cfg_type;

   typedef struct packed {
      logic                 frame_done;
      logic [AddrWidth-1:0] frame_address;
      logic [CmdWidth-1:0]  frame_command;
      logic                 toggle_bit;
      logic                 accepted;
      logic [LampCount-1:0] lamp_state;
   } result_type;

endpackage

[design/rc5ir_csr.sv]
// Configuration registers of the RC5 decoder: delays and address filter.
// Depends on rc5ir_pkg.
module rc5ir_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [rc5ir_pkg::CsrIndexWidth-1:0]   wr_index,
   input  logic [rc5ir_pkg::DelayWidth-1:0]      wr_data,
   output rc5ir_pkg::cfg_type                    cfg
);
   import rc5ir_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CsrFirstDelay:   cfg_in.first_delay   = wr_data;
            CsrBitDelay:     cfg_in.bit_delay     = wr_data;
            CsrAddressMatch: cfg_in.address_match = wr_data[AddrWidth-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay   <= FirstDelayReset;
         cfg_ff.bit_delay     <= BitDelayReset;
         cfg_ff.address_match <= AddressMatchReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/rc5ir_frame.sv]
// Frame sequencer of the RC5 decoder: tick counter, bit shifter, toggle
// memory and lamp lines. Processes one registered pin sample per step.
// Depends on rc5ir_pkg.
module rc5ir_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   level,
   input  rc5ir_pkg::cfg_type     cfg,
   output rc5ir_pkg::result_type  result
);
   import rc5ir_pkg::*;

   typedef enum logic {IDLE, FRAME} state_type;

   state_type              state_ff,  state_in;
   logic [DelayWidth-1:0]  tick_ff,   tick_in;
   logic [BitIdxWidth-1:0] bit_ff,    bit_in;
   logic [FrameBits-1:0]   shift_ff,  shift_in;
   logic                   toggle_ff, toggle_in;
   logic [LampCount-1:0]   lamps_ff,  lamps_in;

   logic [DelayWidth-1:0] tick_next;
   logic [DelayWidth-1:0] need_raw;
   logic [DelayWidth-1:0] need;
   logic [2:0]            lamp_sel;

   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      toggle_in = toggle_ff;
      lamps_in  = lamps_ff;
      result    = '0;

      tick_next = tick_ff + 16'd1;
      need_raw  = (bit_ff == '0) ? cfg.first_delay : cfg.bit_delay;
      // a zero delay behaves as one tick
      need      = (need_raw == '0) ? 16'd1 : need_raw;
      lamp_sel  = shift_in[2:0] - 3'd1;

      unique case (state_ff)
         IDLE: begin
            if (!level) begin
               state_in = FRAME;
               tick_in  = '0;
               bit_in   = '0;
               shift_in = '0;
            end
         end
         FRAME: begin
            if (tick_next < need) begin
               tick_in = tick_next;
            end else begin
               tick_in  = '0;
               shift_in = {shift_ff[FrameBits-2:0], level};
               lamp_sel = shift_in[2:0] - 3'd1;
               if (bit_ff == LastBitIndex) begin
                  state_in             = IDLE;
                  bit_in               = '0;
                  result.frame_done    = 1'b1;
                  result.toggle_bit    = shift_in[FrameBits-1];
                  result.frame_address = shift_in[CmdWidth +: AddrWidth];
                  result.frame_command = shift_in[CmdWidth-1:0];
                  result.accepted      = (result.frame_address == cfg.address_match) &&
                                         (result.toggle_bit != toggle_ff);
                  if (result.accepted) begin
                     toggle_in = result.toggle_bit;
                     if (result.frame_command >= CmdLampLo &&
                         result.frame_command <= CmdLampHi) begin
                        lamps_in = lamps_ff ^ (LampCount'(1) << lamp_sel);
                     end
                  end
                  result.lamp_state = lamps_in;
               end else begin
                  bit_in = bit_ff + 4'd1;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         toggle_ff <= 1'b0;
         lamps_ff  <= '0;
      end else if (step_en) begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         toggle_ff <= toggle_in;
         lamps_ff  <= lamps_in;
      end
   end

`ifndef SYNTHESIS
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= LastBitIndex)
      else $error("bit index past end of frame");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> (tick_ff == '0 && bit_ff == '0))
      else $error("idle with stale counters");

   a_lamps_hold: assert property (@(posedge clock) disable iff (reset)
      !(step_en && result.accepted) |=> $stable(lamps_ff))
      else $error("lamps changed without an accepted frame");

   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> $countones(lamps_ff ^ $past(lamps_ff)) <= 1)
      else $error("more than one lamp flipped");

   a_toggle_hold: assert property (@(posedge clock) disable iff (reset)
      !(step_en && result.accepted) |=> $stable(toggle_ff))
      else $error("toggle recorded without an accepted frame");
`endif

endmodule

[design/rc5_ir_frame_decoder.sv]
// Top level of the RC5 infrared frame decoder: input register, frame
// sequencer, configuration registers and result register.
// Depends on rc5ir_pkg, rc5ir_csr and rc5ir_frame.

// One receiver sample is taken per timing tick and the decoder accepts a
// sample every clock cycle unless the input register stalls. A sample goes
// into an input register and is worked by the frame sequencer; the frame
// report of the sample that completes a frame is captured in the result
// register that drives the rsp_ channel. Samples that do not complete a
// frame give no result. The input register stalls only while a report
// waits in the result register and rsp_ready is low. Configuration writes
// are taken at any time (csr_ready is always high) and should be made while
// no frame is in progress.
module rc5_ir_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_ir_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rc5ir_pkg::AddrWidth-1:0]      rsp_frame_address,
   output logic [rc5ir_pkg::CmdWidth-1:0]       rsp_frame_command,
   output logic                                 rsp_toggle_bit,
   output logic                                 rsp_accepted,
   output logic [rc5ir_pkg::LampCount-1:0]      rsp_lamp_state,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rc5ir_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [rc5ir_pkg::DelayWidth-1:0]     csr_data
);
   import rc5ir_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_level_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   cfg_type    cfg;
   result_type result;
   logic       step_en;
   logic       req_fire;

   assign csr_ready = 1'b1;

   rc5ir_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // sample moves on when the result slot is free or being emptied
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_fire  = req_valid && req_ready;

   rc5ir_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .level   (in_level_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en && result.frame_done) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_level_ff <= req_ir_level;
      end
      if (step_en && result.frame_done) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_address = out_ff.frame_address;
   assign rsp_frame_command = out_ff.frame_command;
   assign rsp_toggle_bit    = out_ff.toggle_bit;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_lamp_state    = out_ff.lamp_state;

endmodule
